@@ hw/rtl/lbe_pkg.sv @@
// package for the looping breakpoint envelope
// widths, register indexes and command codes; no dependencies
package lbe_pkg;
  localparam int MaxPoints = 16;
  localparam int FracBits = 16;
  localparam int SlotW = 4;
  localparam int StageW = 5;
  localparam int LevelW = 24;
  localparam int PlaceW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegInterpMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLoopLength = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStartValue = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEndValue = 3'd3;
  localparam logic [CfgIdxW-1:0] RegUsedPoints = 3'd4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;
endpackage

@@ hw/rtl/looping_breakpoint_envelope_top.sv @@
// looping breakpoint envelope, top level and only module
// uses lbe_pkg; breakpoints live in one synchronous memory
//
// usage:
//   s_axis carries one item: tuser 0 loads a user breakpoint into the table,
//   tuser 1 evaluates the envelope at a tick position.
//   m_axis carries one result item per evaluate, none per load; tuser marks a
//   result for which no stage held the fraction. cfg_we/cfg_idx/cfg_data write
//   the registers; the user writes only while idle, the block does not check it.
// timing:
//   a load is written to the table while idle. an evaluate runs a bit-serial
//   modulo, a bit-serial scale to the fraction, the stage search which reads
//   two table entries per stage from the breakpoint memory (up to 17 stages),
//   a fetch of the stage breakpoints, and in linear mode a sign split and a
//   bit-serial divide; in hold mode or on a zero-width stage it skips the divide.
//   the next item is taken only once the result is loaded into the output
//   register and the block is idle again.
// reset: registers take their reset values; the table is held as valid bits
//   per entry so an unloaded slot reads as zero, with no clearing pass.
// stall: the result waits in an output register; loads are still taken, and
//   an evaluate that finishes holds in its last step until the register is free.
module looping_breakpoint_envelope_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_slot[3:0], point_place[19:4], point_level[43:20], position[75:44]
  input  logic [79:0] s_axis_tdata,
  // cmd[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // level[23:0], stage_index[28:24]
  output logic [31:0] m_axis_tdata,
  // invalid_envelope[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we,
  input  logic [lbe_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [lbe_pkg::CfgDataW-1:0] cfg_data
);
  import lbe_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMod = 4'd1;
  localparam logic [3:0] StScale = 4'd2;
  localparam logic [3:0] StRdA = 4'd3;
  localparam logic [3:0] StRdB = 4'd4;
  localparam logic [3:0] StChk = 4'd5;
  localparam logic [3:0] StLvA = 4'd6;
  localparam logic [3:0] StLvB = 4'd7;
  localparam logic [3:0] StMul = 4'd8;
  localparam logic [3:0] StDiv = 4'd9;
  localparam logic [3:0] StFix = 4'd10;
  localparam logic [3:0] StOut = 4'd11;

  // configuration registers
  logic              interp_mode;
  logic [31:0]       loop_length;
  logic signed [LevelW-1:0] start_value, end_value;
  logic [4:0]        used_points;

  // breakpoint memory: {place, level}, plus valid bits for reset to zero
  logic [PlaceW+LevelW-1:0] mem [MaxPoints];
  logic [MaxPoints-1:0]     mem_vld;
  logic [PlaceW+LevelW-1:0] rd_data;
  logic                     rd_vld;
  logic [SlotW-1:0]         rd_addr;

  logic [3:0]  state;
  logic [StageW-1:0] prev_stage, start, n, u;
  logic [FracBits-1:0] prev_fraction, frac;
  logic        found;

  // modulo and scale registers
  logic [31:0] len, pos_sh;
  logic [32:0] rem;
  logic [5:0]  cnt;

  // search / interpolation
  logic [FracBits:0] pa;
  logic signed [LevelW-1:0] va;
  logic [FracBits:0]  dp;
  logic               dneg;
  logic signed [42:0] prod;
  logic [41:0] num_mag, quo;
  logic [17:0] drem;
  logic        neg;
  logic signed [42:0] lvl;

  // result register
  logic [LevelW-1:0] out_level;
  logic [StageW-1:0] out_stage;
  logic              out_inv;

  wire [PlaceW-1:0] rd_place = rd_vld ? rd_data[PlaceW+LevelW-1:LevelW] : '0;
  wire signed [LevelW-1:0] rd_level = rd_vld ? rd_data[LevelW-1:0] : '0;

  // entry k of the table, k = n or n+1
  function automatic logic is_start(input logic [StageW:0] k);
    return k == '0;
  endfunction

  assign s_axis_tready = (state == StIdle);
  assign m_axis_tdata = {3'b000, out_stage, out_level};
  assign m_axis_tuser = out_inv;

  wire in_acc = s_axis_tvalid && s_axis_tready;
  wire [SlotW-1:0] in_slot = s_axis_tdata[3:0];
  wire out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= 1'b0;
      loop_length <= 32'd48000;
      start_value <= '0;
      end_value <= '0;
      used_points <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegInterpMode: interp_mode <= cfg_data[0];
        RegLoopLength: loop_length <= cfg_data;
        RegStartValue: start_value <= cfg_data[LevelW-1:0];
        RegEndValue:   end_value <= cfg_data[LevelW-1:0];
        RegUsedPoints: used_points <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == CmdLoad)
      mem[in_slot] <= {s_axis_tdata[19:4], s_axis_tdata[43:20]};
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) mem_vld <= '0;
    else if (in_acc && s_axis_tuser == CmdLoad) mem_vld[in_slot] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    rd_vld <= mem_vld[rd_addr];
  end

  // entry index being read: n in StRdA/StLvA, n+1 in StRdB/StLvB
  logic [StageW:0] k_now;
  always_comb begin
    k_now = (state == StRdB || state == StLvB) ? {1'b0, n} + 1'b1 : {1'b0, n};
    rd_addr = k_now[SlotW-1:0] - 1'b1;
  end

  // entry values come in the cycle after the address, k_reg tracks the index
  logic [StageW:0] k_reg;
  logic [FracBits:0]       e_place;
  logic signed [LevelW-1:0] e_level;
  always_comb begin
    if (is_start(k_reg)) begin
      e_place = '0;
      e_level = start_value;
    end else if (k_reg > {1'b0, u}) begin
      e_place = {1'b1, {FracBits{1'b0}}};
      e_level = end_value;
    end else begin
      e_place = {1'b0, rd_place};
      e_level = rd_level;
    end
  end

  wire [32:0] rem_sh = {rem[31:0], pos_sh[31]};
  wire [FracBits:0] n_inc = {1'b0, n} + 1'b1;
  wire [17:0] drem_sh = {drem[16:0], num_mag[41]};
  wire        div_ge = drem_sh >= {1'b0, dp};
  wire [17:0] drem_nx = div_ge ? drem_sh - {1'b0, dp} : drem_sh;
  wire [41:0] quo_nx = {quo[40:0], div_ge};

  // fraction offset into the stage and level difference of the stage, 18 x 25 bit product
  wire signed [17:0] df = signed'({2'b00, prev_fraction}) - signed'({1'b0, pa});
  wire signed [24:0] dl = 25'(e_level) - 25'(va);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      prev_stage <= '0;
      prev_fraction <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      k_reg <= k_now;
      if (state == StOut && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        StIdle: begin
          if (in_acc && s_axis_tuser == CmdEval) begin
            len <= (loop_length == '0) ? 32'd1 : loop_length;
            pos_sh <= s_axis_tdata[75:44];
            rem <= '0;
            cnt <= '0;
            u <= (used_points > 5'(MaxPoints)) ? 5'(MaxPoints) : used_points;
            state <= StMod;
          end
        end
        // restoring modulo, one bit per cycle
        StMod: begin
          rem <= (rem_sh >= {1'b0, len}) ? rem_sh - {1'b0, len} : rem_sh;
          pos_sh <= {pos_sh[30:0], 1'b0};
          if (cnt == 6'd31) begin
            cnt <= '0;
            state <= StScale;
          end else cnt <= cnt + 1'b1;
        end
        // fraction bits: long division of rem * 2^F by len
        StScale: begin
          rem <= ({rem[31:0], 1'b0} >= {1'b0, len}) ?
                 {rem[31:0], 1'b0} - {1'b0, len} : {rem[31:0], 1'b0};
          frac <= {frac[FracBits-2:0], ({rem[31:0], 1'b0} >= {1'b0, len})};
          cnt <= cnt + 1'b1;
          if (cnt == 6'(FracBits - 1)) begin
            start <= (prev_stage <= u) ? prev_stage : '0;
            n <= (prev_stage <= u) ? prev_stage : '0;
            found <= 1'b0;
            state <= StRdA;
          end
        end
        StRdA: state <= StRdB;
        StRdB: begin
          pa <= e_place;
          state <= StChk;
        end
        StChk: begin
          if ({1'b0, frac} >= pa && {1'b0, frac} < e_place) begin
            found <= 1'b1;
            prev_fraction <= frac;
            prev_stage <= n;
            state <= StLvA;
          end else begin
            if (n == u) n <= '0;
            else n <= n_inc[StageW-1:0];
            if ((n == u ? '0 : n_inc[StageW-1:0]) == start) begin
              prev_stage <= start;
              state <= StLvA;
            end else state <= StRdA;
          end
        end
        StLvA: state <= StLvB;
        StLvB: begin
          pa <= e_place;
          va <= e_level;
          state <= StMul;
        end
        StMul: begin
          // span may be negative for an unsorted table
          dneg <= e_place < pa;
          dp <= (e_place < pa) ? pa - e_place : e_place - pa;
          if (!interp_mode || e_place == pa) begin
            lvl <= 43'(va);
            state <= StOut;
          end else begin
            prod <= df * dl;
            cnt <= 6'd0;
            drem <= '0;
            state <= StFix;
          end
        end
        // sign split before the divide
        StFix: begin
          neg <= prod[42] ^ dneg;
          num_mag <= prod[42] ? 42'(-prod) : prod[41:0];
          quo <= '0;
          state <= StDiv;
        end
        // restoring divide by place span, one bit per cycle
        StDiv: begin
          drem <= drem_nx;
          quo <= quo_nx;
          num_mag <= {num_mag[40:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd41) begin
            // floor toward minus infinity on a negative quotient
            if (neg)
              lvl <= 43'(va) - 43'(quo_nx) - 43'(drem_nx != '0);
            else
              lvl <= 43'(va) + 43'(quo_nx);
            state <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            out_level <= (lvl > 43'sd8388607) ? 24'h7fffff :
                         (lvl < -43'sd8388608) ? 24'h800000 : lvl[23:0];
            out_stage <= prev_stage;
            out_inv <= !found;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
